// ===== hdl/tpc_pkg.sv =====
// shared types and constants for the tree path-cost engine
// no dependencies; every other file imports this package
`default_nettype none
package tpc_pkg;

  localparam int ID_W   = 10;
  localparam int ECST_W = 16;
  localparam int COST_W = 26;
  localparam int SUM_W  = 33;
  localparam logic [COST_W-1:0] MAX_COST = {COST_W{1'b1}};

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_BUILD = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef enum logic [1:0] {
    CLS_ADD,
    CLS_BUILD,
    CLS_QUERY
  } cls_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [ID_W-1:0]   node_a;
    logic [ID_W-1:0]   node_b;
    logic [ECST_W-1:0] edge_cost;
  } tpc_in_t;

  typedef struct packed {
    logic [COST_W-1:0] path_cost;
    logic              found;
  } tpc_out_t;

  typedef struct packed {
    cls_e              cls;
    logic [ID_W-1:0]   node_a;
    logic [ID_W-1:0]   node_b;
    logic [ECST_W-1:0] edge_cost;
    logic              ids_ok;
  } tpc_cmd_t;

  typedef enum logic [5:0] {
    S_INIT, S_IDLE,
    S_ADD_RA, S_ADD_WA, S_ADD_RB, S_ADD_WB,
    S_CLR, S_ROOT_RD, S_ROOT_CHK, S_POP_RD, S_POP_CUR, S_CUR_CHK,
    S_EDGE_RD, S_EDGE_CHK, S_NB_CHK,
    S_LIFT_RD1, S_LIFT_CHK1, S_LIFT_CHK2,
    S_Q_RA, S_Q_RB, S_Q_PRES, S_Q_DA, S_Q_DB,
    S_UP_RD, S_UP_CHK, S_CMP_RA, S_CMP_RB, S_CMP_CHK,
    S_FIN_RA, S_FIN_RB, S_FIN_ADD, S_RESULT
  } state_e;

  function automatic logic [COST_W-1:0] sat_cost(input logic [SUM_W-1:0] v);
    return (v > SUM_W'(MAX_COST)) ? MAX_COST : v[COST_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/tpc_front.sv =====
// front end: input queue of two items, classifies each item
// depends on tpc_pkg
`default_nettype none
module tpc_front import tpc_pkg::*; #(
  parameter int MAX_NODES = 1024
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  output logic          full_o,
  input  wire tpc_in_t  in_item_i,
  input  wire logic     hold_i,
  output logic          cmd_valid_o,
  output tpc_cmd_t      cmd_o,
  input  wire logic     cmd_take_i
);

  tpc_cmd_t   slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       enq, deq;
  tpc_cmd_t   cmd_new;

  always_comb begin
    cmd_new.node_a    = in_item_i.node_a;
    cmd_new.node_b    = in_item_i.node_b;
    cmd_new.edge_cost = in_item_i.edge_cost;
    cmd_new.ids_ok    = (32'(in_item_i.node_a) < 32'(MAX_NODES)) &&
                        (32'(in_item_i.node_b) < 32'(MAX_NODES));
    unique case (in_item_i.action)
      ACT_ADD:   cmd_new.cls = CLS_ADD;
      ACT_BUILD: cmd_new.cls = CLS_BUILD;
      default:   cmd_new.cls = CLS_QUERY;
    endcase
  end

  assign full_o      = hold_i || (cnt_q == 2'd2);
  // unused action code is taken and dropped here
  assign enq         = push_i && !full_o && (in_item_i.action != ACT_SPARE);
  assign deq         = cmd_take_i && cmd_valid_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (enq && !deq) cnt_d = cnt_q + 2'd1;
    else if (deq && !enq) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (enq) wr_q <= !wr_q;
      if (deq) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) slot_q[wr_q] <= cmd_new;
  end

endmodule
`default_nettype wire

// ===== hdl/tpc_back.sv =====
// back end: edge store, depth-first walk, lifting tables and query engine
// depends on tpc_pkg
`default_nettype none
module tpc_back import tpc_pkg::*; #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 10,
  parameter int MAX_EDGES   = 2048,
  parameter int COST_BITS   = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_valid_i,
  input  wire tpc_cmd_t cmd_i,
  output logic          cmd_take_o,
  output logic          init_busy_o,
  output logic          res_valid_o,
  output tpc_out_t      res_o,
  input  wire logic     res_pop_i
);

  localparam int NW  = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int EW  = (MAX_EDGES > 2) ? $clog2(MAX_EDGES) : 1;
  localparam int LW  = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int LVW = $clog2(LIFT_LEVELS + 1);
  localparam int AW  = LW + NW;

  typedef struct packed {
    logic        present;
    logic [EW:0] head;
  } node_ent_t;

  typedef struct packed {
    logic [NW-1:0]        nbr;
    logic [COST_BITS-1:0] wt;
    logic [EW:0]          nxt;
  } edge_ent_t;

  typedef struct packed {
    logic          seen;
    logic [NW-1:0] depth;
  } tree_ent_t;

  typedef struct packed {
    logic [NW:0]       anc;
    logic [COST_W-1:0] cost;
  } anc_ent_t;

  // memories
  node_ent_t node_mem [MAX_NODES];
  edge_ent_t edge_mem [MAX_EDGES];
  tree_ent_t tree_mem [MAX_NODES];
  anc_ent_t  anc_mem  [2**AW];
  logic [NW-1:0] stk_mem [MAX_NODES];

  logic nm_we, em_we, tm_we, am_we, sk_we;
  logic [NW-1:0] nm_wa, nm_ra, tm_wa, tm_ra, sk_wa, sk_ra;
  logic [EW-1:0] em_wa, em_ra;
  logic [AW-1:0] am_wa, am_ra;
  node_ent_t nm_wd, nm_rd_q;
  edge_ent_t em_wd, em_rd_q;
  tree_ent_t tm_wd, tm_rd_q;
  anc_ent_t  am_wd, am_rd_q;
  logic [NW-1:0] sk_wd, sk_rd_q;

  always_ff @(posedge clk_i) begin
    if (nm_we) node_mem[nm_wa] <= nm_wd;
    nm_rd_q <= node_mem[nm_ra];
  end
  always_ff @(posedge clk_i) begin
    if (em_we) edge_mem[em_wa] <= em_wd;
    em_rd_q <= edge_mem[em_ra];
  end
  always_ff @(posedge clk_i) begin
    if (tm_we) tree_mem[tm_wa] <= tm_wd;
    tm_rd_q <= tree_mem[tm_ra];
  end
  always_ff @(posedge clk_i) begin
    if (am_we) anc_mem[am_wa] <= am_wd;
    am_rd_q <= anc_mem[am_ra];
  end
  always_ff @(posedge clk_i) begin
    if (sk_we) stk_mem[sk_wa] <= sk_wd;
    sk_rd_q <= stk_mem[sk_ra];
  end

  state_e state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [NW:0]   sp_q, sp_d;
  logic [EW:0]   ecnt_q, ecnt_d;
  logic [NW-1:0] a_q, a_d, b_q, b_d, cur_q, cur_d, nb_q, nb_d;
  logic [NW-1:0] dcur_q, dcur_d, da_q, da_d, diff_q, diff_d;
  logic [COST_BITS-1:0] w_q, w_d;
  logic [EW:0]   e_q, e_d;
  logic          pa_q, pa_d, found_q, found_d;
  logic [LVW-1:0] lvl_q, lvl_d;
  logic [COST_W-1:0] cost_q, cost_d, ca_q, ca_d;
  logic [NW:0]   ua_q, ua_d;
  logic          res_valid_q, res_valid_d;
  tpc_out_t      res_q, res_d;

  logic cnt_last, lvl_top, lift_last, edge_room, res_free, dbit, sp_room;
  logic [SUM_W-1:0] sum_up, sum_cmp, sum_lift;
  logic [LVW-1:0] lvl_dn;

  function automatic logic [AW-1:0] am_addr(input logic [LVW-1:0] lv,
                                            input logic [NW-1:0] n);
    return {LW'(lv), n};
  endfunction

  assign cnt_last  = (cnt_q == NW'(MAX_NODES - 1));
  assign lvl_top   = (lvl_q == LVW'(LIFT_LEVELS));
  assign lift_last = (lvl_q == LVW'(LIFT_LEVELS - 1));
  assign edge_room = ((EW+2)'(ecnt_q) + (EW+2)'(2)) <= (EW+2)'(MAX_EDGES);
  assign res_free  = !res_valid_q || res_pop_i;
  assign dbit      = |(diff_q & (NW'(1) << lvl_q));
  assign sp_room   = (sp_q < (NW+1)'(MAX_NODES));
  assign lvl_dn    = lvl_q - LVW'(1);
  assign sum_up    = SUM_W'(cost_q) + SUM_W'(am_rd_q.cost);
  assign sum_cmp   = SUM_W'(cost_q) + SUM_W'(ca_q) + SUM_W'(am_rd_q.cost);
  assign sum_lift  = SUM_W'(ca_q) + SUM_W'(am_rd_q.cost);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:     if (cnt_last) state_d = S_IDLE;
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.cls)
            CLS_ADD:   state_d = (cmd_i.ids_ok && edge_room) ? S_ADD_RA : S_IDLE;
            CLS_BUILD: state_d = S_CLR;
            default:   state_d = cmd_i.ids_ok ? S_Q_RA : S_RESULT;
          endcase
        end
      end
      S_ADD_RA:   state_d = S_ADD_WA;
      S_ADD_WA:   state_d = S_ADD_RB;
      S_ADD_RB:   state_d = S_ADD_WB;
      S_ADD_WB:   state_d = S_IDLE;
      S_CLR:      if (cnt_last) state_d = S_ROOT_RD;
      S_ROOT_RD:  state_d = S_ROOT_CHK;
      S_ROOT_CHK: begin
        if (nm_rd_q.present && !tm_rd_q.seen) state_d = S_POP_RD;
        else if (!cnt_last) state_d = S_ROOT_RD;
        else state_d = (LIFT_LEVELS > 1) ? S_LIFT_RD1 : S_IDLE;
      end
      S_POP_RD: begin
        if (sp_q != '0) state_d = S_POP_CUR;
        else if (!cnt_last) state_d = S_ROOT_RD;
        else state_d = (LIFT_LEVELS > 1) ? S_LIFT_RD1 : S_IDLE;
      end
      S_POP_CUR:  state_d = S_CUR_CHK;
      S_CUR_CHK:  state_d = S_EDGE_RD;
      S_EDGE_RD:  state_d = (e_q == '0) ? S_POP_RD : S_EDGE_CHK;
      S_EDGE_CHK: state_d = S_NB_CHK;
      S_NB_CHK:   state_d = S_EDGE_RD;
      S_LIFT_RD1: state_d = S_LIFT_CHK1;
      S_LIFT_CHK1: begin
        if (am_rd_q.anc != '0) state_d = S_LIFT_CHK2;
        else if (cnt_last && lift_last) state_d = S_IDLE;
        else state_d = S_LIFT_RD1;
      end
      S_LIFT_CHK2: state_d = (cnt_last && lift_last) ? S_IDLE : S_LIFT_RD1;
      S_Q_RA:     state_d = S_Q_RB;
      S_Q_RB:     state_d = S_Q_PRES;
      S_Q_PRES:   state_d = (pa_q && nm_rd_q.present) ? S_Q_DA : S_RESULT;
      S_Q_DA:     state_d = S_Q_DB;
      S_Q_DB:     state_d = S_UP_RD;
      S_UP_RD: begin
        if (lvl_top) state_d = (a_q == b_q) ? S_RESULT : S_CMP_RA;
        else if (dbit) state_d = S_UP_CHK;
      end
      S_UP_CHK:   state_d = S_UP_RD;
      S_CMP_RA:   state_d = (lvl_q == '0) ? S_FIN_RA : S_CMP_RB;
      S_CMP_RB:   state_d = S_CMP_CHK;
      S_CMP_CHK:  state_d = S_CMP_RA;
      S_FIN_RA:   state_d = S_FIN_RB;
      S_FIN_RB:   state_d = S_FIN_ADD;
      S_FIN_ADD:  state_d = S_RESULT;
      S_RESULT:   if (res_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    cnt_d = cnt_q; sp_d = sp_q; ecnt_d = ecnt_q;
    a_d = a_q; b_d = b_q; cur_d = cur_q; nb_d = nb_q;
    dcur_d = dcur_q; da_d = da_q; diff_d = diff_q; w_d = w_q; e_d = e_q;
    pa_d = pa_q; found_d = found_q; lvl_d = lvl_q;
    cost_d = cost_q; ca_d = ca_q; ua_d = ua_q;
    res_valid_d = res_valid_q && !res_pop_i;
    res_d = res_q;
    nm_we = 1'b0; nm_wa = '0; nm_wd = '0; nm_ra = '0;
    em_we = 1'b0; em_wa = '0; em_wd = '0; em_ra = '0;
    tm_we = 1'b0; tm_wa = '0; tm_wd = '0; tm_ra = '0;
    am_we = 1'b0; am_wa = '0; am_wd = '0; am_ra = '0;
    sk_we = 1'b0; sk_wa = '0; sk_wd = '0; sk_ra = '0;
    unique case (state_q)
      S_INIT: begin
        nm_we = 1'b1; nm_wa = cnt_q;
        cnt_d = cnt_last ? '0 : cnt_q + NW'(1);
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          a_d = NW'(cmd_i.node_a);
          b_d = NW'(cmd_i.node_b);
          w_d = COST_BITS'(cmd_i.edge_cost);
          cnt_d = '0;
          cost_d = '0;
          found_d = 1'b0;
        end
      end
      S_ADD_RA: nm_ra = a_q;
      S_ADD_WA, S_ADD_WB: begin
        em_we = 1'b1; em_wa = EW'(ecnt_q);
        em_wd.nbr = (state_q == S_ADD_WA) ? b_q : a_q;
        em_wd.wt = w_q; em_wd.nxt = nm_rd_q.head;
        nm_we = 1'b1; nm_wa = (state_q == S_ADD_WA) ? a_q : b_q;
        nm_wd.present = 1'b1; nm_wd.head = ecnt_q + (EW+1)'(1);
        ecnt_d = ecnt_q + (EW+1)'(1);
      end
      S_ADD_RB: nm_ra = b_q;
      S_CLR: begin
        tm_we = 1'b1; tm_wa = cnt_q;
        am_we = 1'b1; am_wa = am_addr('0, cnt_q);
        cnt_d = cnt_last ? '0 : cnt_q + NW'(1);
        sp_d = '0;
      end
      S_ROOT_RD: begin
        nm_ra = cnt_q; tm_ra = cnt_q;
      end
      S_ROOT_CHK: begin
        if (nm_rd_q.present && !tm_rd_q.seen) begin
          tm_we = 1'b1; tm_wa = cnt_q; tm_wd.seen = 1'b1;
          sk_we = 1'b1; sk_wa = '0; sk_wd = cnt_q;
          sp_d = (NW+1)'(1);
        end else if (!cnt_last) begin
          cnt_d = cnt_q + NW'(1);
        end else begin
          cnt_d = '0; lvl_d = LVW'(1);
        end
      end
      S_POP_RD: begin
        if (sp_q != '0) begin
          sk_ra = NW'(sp_q - (NW+1)'(1));
          sp_d = sp_q - (NW+1)'(1);
        end else if (!cnt_last) begin
          cnt_d = cnt_q + NW'(1);
        end else begin
          cnt_d = '0; lvl_d = LVW'(1);
        end
      end
      S_POP_CUR: begin
        cur_d = sk_rd_q; nm_ra = sk_rd_q; tm_ra = sk_rd_q;
      end
      S_CUR_CHK: begin
        e_d = nm_rd_q.head; dcur_d = tm_rd_q.depth;
      end
      S_EDGE_RD: em_ra = EW'(e_q - (EW+1)'(1));
      S_EDGE_CHK: begin
        nb_d = em_rd_q.nbr; w_d = em_rd_q.wt; e_d = em_rd_q.nxt;
        tm_ra = em_rd_q.nbr;
      end
      S_NB_CHK: begin
        if (!tm_rd_q.seen) begin
          tm_we = 1'b1; tm_wa = nb_q;
          tm_wd.seen = 1'b1; tm_wd.depth = dcur_q + NW'(1);
          am_we = 1'b1; am_wa = am_addr('0, nb_q);
          am_wd.anc = (NW+1)'(cur_q) + (NW+1)'(1);
          am_wd.cost = sat_cost(SUM_W'(w_q));
          if (sp_room) begin
            sk_we = 1'b1; sk_wa = NW'(sp_q); sk_wd = nb_q;
            sp_d = sp_q + (NW+1)'(1);
          end
        end
      end
      S_LIFT_RD1: am_ra = am_addr(lvl_dn, cnt_q);
      S_LIFT_CHK1, S_LIFT_CHK2: begin
        am_we = (state_q == S_LIFT_CHK2) || (am_rd_q.anc == '0);
        am_wa = am_addr(lvl_q, cnt_q);
        if (state_q == S_LIFT_CHK2 && am_rd_q.anc != '0) begin
          am_wd.anc = am_rd_q.anc; am_wd.cost = sat_cost(sum_lift);
        end
        if (state_q == S_LIFT_CHK1 && am_rd_q.anc != '0) begin
          ca_d = am_rd_q.cost;
          am_ra = am_addr(lvl_dn, NW'(am_rd_q.anc - (NW+1)'(1)));
        end else if (cnt_last) begin
          cnt_d = '0; lvl_d = lvl_q + LVW'(1);
        end else begin
          cnt_d = cnt_q + NW'(1);
        end
      end
      S_Q_RA: nm_ra = a_q;
      S_Q_RB: begin
        pa_d = nm_rd_q.present; nm_ra = b_q;
      end
      S_Q_PRES: begin
        tm_ra = a_q;
        found_d = pa_q && nm_rd_q.present;
      end
      S_Q_DA: begin
        da_d = tm_rd_q.depth; tm_ra = b_q;
      end
      S_Q_DB: begin
        lvl_d = '0;
        // lift the deeper node first
        if (da_q < tm_rd_q.depth) begin
          a_d = b_q; b_d = a_q; diff_d = tm_rd_q.depth - da_q;
        end else begin
          diff_d = da_q - tm_rd_q.depth;
        end
      end
      S_UP_RD: begin
        if (!lvl_top) begin
          am_ra = am_addr(lvl_q, a_q);
          if (!dbit) lvl_d = lvl_q + LVW'(1);
        end
      end
      S_UP_CHK: begin
        if (am_rd_q.anc != '0) begin
          cost_d = sat_cost(sum_up);
          a_d = NW'(am_rd_q.anc - (NW+1)'(1));
        end
        lvl_d = lvl_q + LVW'(1);
      end
      S_CMP_RA: am_ra = am_addr(lvl_dn, a_q);
      S_CMP_RB: begin
        ua_d = am_rd_q.anc; ca_d = am_rd_q.cost;
        am_ra = am_addr(lvl_dn, b_q);
      end
      S_CMP_CHK: begin
        if (ua_q != '0 && am_rd_q.anc != '0 && ua_q != am_rd_q.anc) begin
          cost_d = sat_cost(sum_cmp);
          a_d = NW'(ua_q - (NW+1)'(1));
          b_d = NW'(am_rd_q.anc - (NW+1)'(1));
        end
        lvl_d = lvl_dn;
      end
      S_FIN_RA: am_ra = am_addr('0, a_q);
      S_FIN_RB: begin
        ca_d = am_rd_q.cost; am_ra = am_addr('0, b_q);
      end
      S_FIN_ADD: cost_d = sat_cost(sum_cmp);
      S_RESULT: begin
        if (res_free) begin
          res_valid_d = 1'b1;
          res_d.path_cost = found_q ? cost_q : '0;
          res_d.found = found_q;
        end
      end
      default: ;
    endcase
  end

  // handshake outputs
  always_comb begin
    cmd_take_o  = (state_q == S_IDLE) && cmd_valid_i;
    init_busy_o = (state_q == S_INIT);
    res_valid_o = res_valid_q;
    res_o       = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      sp_q        <= '0;
      ecnt_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sp_q        <= sp_d;
      ecnt_q      <= ecnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; cur_q <= cur_d; nb_q <= nb_d;
    dcur_q <= dcur_d; da_q <= da_d; diff_q <= diff_d; w_q <= w_d; e_q <= e_d;
    pa_q <= pa_d; found_q <= found_d; lvl_q <= lvl_d;
    cost_q <= cost_d; ca_q <= ca_d; ua_q <= ua_d; res_q <= res_d;
  end

endmodule
`default_nettype wire

// ===== hdl/tree_path_cost_lca.sv =====
// build: a clearing pass over the tree table, then a depth-first walk from each present node
// not yet reached, then the lifting tables filled level by level for LIFT_LEVELS-1 levels
// one item at a time in the back end; a two-item queue in front keeps taking items until full
// reset: clearing pass over the node table, full stays high meanwhile
// depends on tpc_pkg, tpc_front, tpc_back
`default_nettype none
module tree_path_cost_lca import tpc_pkg::*; #(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 10,
  parameter int MAX_EDGES   = 2048,
  parameter int COST_BITS   = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  output logic         full_o,
  input  wire tpc_in_t in_item_i,
  output logic         empty_o,
  input  wire logic    pop_i,
  output tpc_out_t     out_item_o
);

  // front to back command channel
  logic     cmd_valid, cmd_take, init_busy, res_valid;
  tpc_cmd_t cmd;

  // front: buffers and classifies each item
  tpc_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_item_i   (in_item_i),
    .hold_i      (init_busy),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // back: memories, walk, table fill and lifting query, one result register
  tpc_back #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS),
    .MAX_EDGES   (MAX_EDGES),
    .COST_BITS   (COST_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .init_busy_o (init_busy),
    .res_valid_o (res_valid),
    .res_o       (out_item_o),
    .res_pop_i   (pop_i && res_valid)
  );

  // result side looks like a queue
  assign empty_o = !res_valid;

endmodule
`default_nettype wire
